>>> hw/rtl/gbar_pkg.sv
// Shared types, constants and timing tables for the gamepad button autorepeat block.
`timescale 1ns / 1ps
package gbar_pkg;

    localparam int BUTTON_COUNT_DEF = 20;
    localparam int MASK_W           = 20;
    localparam int AXIS_W           = 16;
    localparam int RAW_W            = 16;
    localparam int TIME_W           = 32;
    localparam int SPAN_W           = 10;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int DIR_COUNT        = 4;

    localparam logic [AXIS_W-1:0] HAT_UP    = 16'd0;
    localparam logic [AXIS_W-1:0] HAT_RIGHT = 16'd9000;
    localparam logic [AXIS_W-1:0] HAT_DOWN  = 16'd18000;
    localparam logic [AXIS_W-1:0] HAT_LEFT  = 16'd27000;

    localparam int DIV3_SHIFT = 17;
    localparam logic [16:0] DIV3_RECIP = 17'd43691;

    localparam logic [AXIS_W-1:0] X_MIN_RST = 16'd0;
    localparam logic [AXIS_W-1:0] X_MAX_RST = 16'hFFFF;
    localparam logic [AXIS_W-1:0] Y_MIN_RST = 16'd0;
    localparam logic [AXIS_W-1:0] Y_MAX_RST = 16'hFFFF;
    localparam logic [1:0]        DELAY_RST = 2'd1;
    localparam logic [4:0]        SPEED_RST = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_MIN,
        REG_X_MAX,
        REG_Y_MIN,
        REG_Y_MAX,
        REG_HAS_HAT,
        REG_DELAY,
        REG_SPEED
    } gbar_cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THX,
        ST_THY,
        ST_PRESS,
        ST_WALK,
        ST_OUT
    } gbar_state_t;

    typedef struct packed {
        logic load;
        logic thr_x;
        logic thr_y;
        logic press;
        logic walk;
        logic emit;
    } gbar_cmd_t;

    typedef struct packed {
        logic last;
    } gbar_sts_t;

    function automatic logic [SPAN_W-1:0] first_delay(input logic [1:0] code);
        logic [SPAN_W-1:0] span;
        case (code)
            2'd0:    span = 10'd250;
            2'd1:    span = 10'd500;
            2'd2:    span = 10'd750;
            2'd3:    span = 10'd1000;
            default: span = 10'd1000;
        endcase
        return span;
    endfunction

    // 1000 / (code + 2), truncated
    function automatic logic [SPAN_W-1:0] repeat_period(input logic [4:0] code);
        logic [SPAN_W-1:0] span;
        case (code)
            5'd0:    span = 10'd500;
            5'd1:    span = 10'd333;
            5'd2:    span = 10'd250;
            5'd3:    span = 10'd200;
            5'd4:    span = 10'd166;
            5'd5:    span = 10'd142;
            5'd6:    span = 10'd125;
            5'd7:    span = 10'd111;
            5'd8:    span = 10'd100;
            5'd9:    span = 10'd90;
            5'd10:   span = 10'd83;
            5'd11:   span = 10'd76;
            5'd12:   span = 10'd71;
            5'd13:   span = 10'd66;
            5'd14:   span = 10'd62;
            5'd15:   span = 10'd58;
            5'd16:   span = 10'd55;
            5'd17:   span = 10'd52;
            5'd18:   span = 10'd50;
            5'd19:   span = 10'd47;
            5'd20:   span = 10'd45;
            5'd21:   span = 10'd43;
            5'd22:   span = 10'd41;
            5'd23:   span = 10'd40;
            5'd24:   span = 10'd38;
            5'd25:   span = 10'd37;
            5'd26:   span = 10'd35;
            5'd27:   span = 10'd34;
            5'd28:   span = 10'd33;
            5'd29:   span = 10'd32;
            5'd30:   span = 10'd31;
            5'd31:   span = 10'd30;
            default: span = 10'd30;
        endcase
        return span;
    endfunction

endpackage

>>> hw/rtl/gbar_ctrl.sv
// Sequencer for the autorepeat block: sample capture, threshold setup, button walk, result beat.
`timescale 1ns / 1ps
module gbar_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  gbar_pkg::gbar_sts_t sts,
    output gbar_pkg::gbar_cmd_t cmd
);
    import gbar_pkg::*;

    gbar_state_t state_reg;
    gbar_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_THX;
                end
            end
            ST_THX:
            begin
                cmd.thr_x  = 1'b1;
                state_next = ST_THY;
            end
            ST_THY:
            begin
                cmd.thr_y  = 1'b1;
                state_next = ST_PRESS;
            end
            ST_PRESS:
            begin
                cmd.press  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

>>> hw/rtl/gbar_dp.sv
// Datapath for the autorepeat block: config registers, thresholds, button state memory, masks.
`timescale 1ns / 1ps
module gbar_dp #(
    parameter int BUTTON_COUNT = gbar_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gbar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbar_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [gbar_pkg::AXIS_W-1:0]         x_pos,
    input  logic [gbar_pkg::AXIS_W-1:0]         y_pos,
    input  logic [gbar_pkg::AXIS_W-1:0]         hat_angle,
    input  logic [gbar_pkg::RAW_W-1:0]          raw_buttons,
    input  logic [gbar_pkg::TIME_W-1:0]         now_ms,
    input  gbar_pkg::gbar_cmd_t                 cmd,
    output gbar_pkg::gbar_sts_t                 sts,
    output logic [gbar_pkg::MASK_W-1:0]         fire_mask,
    output logic [gbar_pkg::MASK_W-1:0]         held_mask
);
    import gbar_pkg::*;

    localparam int CW     = $clog2(BUTTON_COUNT);
    localparam int WORD_W = TIME_W + 1;

    logic [AXIS_W-1:0] x_min_reg;
    logic [AXIS_W-1:0] x_max_reg;
    logic [AXIS_W-1:0] y_min_reg;
    logic [AXIS_W-1:0] y_max_reg;
    logic              has_hat_reg;
    logic [1:0]        delay_reg;
    logic [4:0]        speed_reg;

    logic [AXIS_W-1:0] x_pos_reg;
    logic [AXIS_W-1:0] y_pos_reg;
    logic [AXIS_W-1:0] hat_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [TIME_W-1:0] now_reg;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] d_sel;
    logic [AXIS_W-1:0]  mag;
    logic [32:0]        prod;
    logic [AXIS_W-1:0]  quot;
    logic signed [16:0] sq;
    logic signed [16:0] sq_x_reg;
    logic signed [16:0] sq_y_reg;

    logic signed [17:0] lo_x;
    logic signed [17:0] hi_x;
    logic signed [17:0] lo_y;
    logic signed [17:0] hi_y;
    logic [BUTTON_COUNT-1:0]       press_vec;
    logic [RAW_W+BUTTON_COUNT-1:0] raw_ext;

    logic [BUTTON_COUNT-1:0] press_reg;
    logic [BUTTON_COUNT-1:0] held_reg;
    logic [BUTTON_COUNT-1:0] fire_reg;
    logic [CW-1:0]           idx_reg;

    logic [WORD_W-1:0] button_mem_reg [BUTTON_COUNT];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [CW-1:0]     rd_addr;

    logic              cur_press;
    logic              cur_held;
    logic [SPAN_W-1:0] span;
    logic [TIME_W-1:0] elapsed;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;

    logic [MASK_W+BUTTON_COUNT-1:0] fire_ext;
    logic [MASK_W+BUTTON_COUNT-1:0] held_ext;
    logic [MASK_W-1:0]              fire_mask_reg;
    logic [MASK_W-1:0]              held_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg   <= X_MIN_RST;
            x_max_reg   <= X_MAX_RST;
            y_min_reg   <= Y_MIN_RST;
            y_max_reg   <= Y_MAX_RST;
            has_hat_reg <= 1'b0;
            delay_reg   <= DELAY_RST;
            speed_reg   <= SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (gbar_cfg_reg_t'(cfg_index))
                REG_X_MIN:   x_min_reg   <= cfg_data;
                REG_X_MAX:   x_max_reg   <= cfg_data;
                REG_Y_MIN:   y_min_reg   <= cfg_data;
                REG_Y_MAX:   y_max_reg   <= cfg_data;
                REG_HAS_HAT: has_hat_reg <= cfg_data[0];
                REG_DELAY:   delay_reg   <= cfg_data[1:0];
                REG_SPEED:   speed_reg   <= cfg_data[4:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_pos_reg <= x_pos;
            y_pos_reg <= y_pos;
            hat_reg   <= hat_angle;
            raw_reg   <= raw_buttons;
            now_reg   <= now_ms;
        end
    end

    // span / 3 truncated toward zero, through one shared reciprocal multiply
    assign dx    = $signed({1'b0, x_max_reg}) - $signed({1'b0, x_min_reg});
    assign dy    = $signed({1'b0, y_max_reg}) - $signed({1'b0, y_min_reg});
    assign d_sel = cmd.thr_y ? dy : dx;
    assign mag   = d_sel[16] ? AXIS_W'(-d_sel) : d_sel[AXIS_W-1:0];
    assign prod  = 33'(mag) * 33'(DIV3_RECIP);
    assign quot  = prod[DIV3_SHIFT+AXIS_W-1:DIV3_SHIFT];
    assign sq    = d_sel[16] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_ff @(posedge clk)
    begin
        if (cmd.thr_x)
        begin
            sq_x_reg <= sq;
        end
        if (cmd.thr_y)
        begin
            sq_y_reg <= sq;
        end
    end

    assign lo_x = $signed({2'b00, x_min_reg}) + $signed({sq_x_reg[16], sq_x_reg});
    assign hi_x = $signed({2'b00, x_max_reg}) - $signed({sq_x_reg[16], sq_x_reg});
    assign lo_y = $signed({2'b00, y_min_reg}) + $signed({sq_y_reg[16], sq_y_reg});
    assign hi_y = $signed({2'b00, y_max_reg}) - $signed({sq_y_reg[16], sq_y_reg});
    assign raw_ext = {{BUTTON_COUNT{1'b0}}, raw_reg};

    always_comb
    begin
        press_vec    = '0;
        press_vec[0] = ($signed({2'b00, y_pos_reg}) < lo_y)
                       || (has_hat_reg && (hat_reg == HAT_UP));
        press_vec[1] = ($signed({2'b00, y_pos_reg}) > hi_y)
                       || (has_hat_reg && (hat_reg == HAT_DOWN));
        press_vec[2] = ($signed({2'b00, x_pos_reg}) < lo_x)
                       || (has_hat_reg && (hat_reg == HAT_LEFT));
        press_vec[3] = ($signed({2'b00, x_pos_reg}) > hi_x)
                       || (has_hat_reg && (hat_reg == HAT_RIGHT));
        for (int j = DIR_COUNT; j < BUTTON_COUNT; j++)
        begin
            press_vec[j] = raw_ext[j-DIR_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.press)
        begin
            press_reg <= press_vec;
        end
    end

    assign sts.last = (idx_reg == CW'(BUTTON_COUNT - 1));
    assign rd_en    = cmd.press || (cmd.walk && !sts.last);
    assign rd_addr  = cmd.press ? '0 : idx_reg + CW'(1);

    assign cur_press = press_reg[idx_reg];
    assign cur_held  = held_reg[idx_reg];
    assign span      = rd_data_reg[TIME_W] ? repeat_period(speed_reg) : first_delay(delay_reg);
    assign elapsed   = now_reg - rd_data_reg[TIME_W-1:0];
    assign wr_en     = cmd.walk && cur_press
                       && (!cur_held || (elapsed >= TIME_W'(span)));
    assign wr_data   = {cur_held, now_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            button_mem_reg[idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= button_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (cmd.walk)
        begin
            held_reg[idx_reg] <= cur_press;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.press)
        begin
            idx_reg  <= '0;
            fire_reg <= '0;
        end
        else if (cmd.walk)
        begin
            idx_reg           <= idx_reg + CW'(1);
            fire_reg[idx_reg] <= wr_en;
        end
    end

    assign fire_ext = {{MASK_W{1'b0}}, fire_reg};
    assign held_ext = {{MASK_W{1'b0}}, held_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            fire_mask_reg <= fire_ext[MASK_W-1:0];
            held_mask_reg <= held_ext[MASK_W-1:0];
        end
    end

    assign fire_mask = fire_mask_reg;
    assign held_mask = held_mask_reg;

endmodule

>>> hw/rtl/gamepad_button_autorepeat.sv
// Top level of the gamepad button autorepeat block.
//
// One sample beat (axes, hat angle, raw buttons, millisecond tick) yields one
// result beat with the fire and held masks of all virtual buttons: up, down,
// left, right, then the raw buttons.
// Sample channel: sample_valid / sample_stall; stall is high while a sample
// is in work. Result channel: result_valid / result_stall, from an output
// register, so a new sample is taken while the previous result still waits.
// Config channel: cfg_valid / cfg_ready, ready always high; write only while
// no sample is in work. Unknown indexes are ignored.
// Steps from accept to result: the X and then the Y threshold through the
// shared divide-by-3 multiplier, the press decode, a walk over the buttons
// in index order that reads the per-button timestamp memory with its single
// read port, and the load of the result register. The next sample is taken
// in the cycle after that load at the earliest, so a new sample is never
// accepted while the previous one is still in work.
// A stalled receiver holds the result and holds the sequencer at its end.
// Reset clears the held flags and restores the config defaults. Timestamps
// are written at each new press and repeat fire, and used only while held.
`timescale 1ns / 1ps
module gamepad_button_autorepeat #(
    parameter int BUTTON_COUNT = gbar_pkg::BUTTON_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbar_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [gbar_pkg::AXIS_W-1:0]     x_pos,
    input  logic [gbar_pkg::AXIS_W-1:0]     y_pos,
    input  logic [gbar_pkg::AXIS_W-1:0]     hat_angle,
    input  logic [gbar_pkg::RAW_W-1:0]      raw_buttons,
    input  logic [gbar_pkg::TIME_W-1:0]     now_ms,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [gbar_pkg::MASK_W-1:0]     fire_mask,
    output logic [gbar_pkg::MASK_W-1:0]     held_mask
);
    import gbar_pkg::*;

    gbar_cmd_t cmd;
    gbar_sts_t sts;
    logic      cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    gbar_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    gbar_dp #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .hat_angle   (hat_angle),
        .raw_buttons (raw_buttons),
        .now_ms      (now_ms),
        .cmd         (cmd),
        .sts         (sts),
        .fire_mask   (fire_mask),
        .held_mask   (held_mask)
    );

endmodule

>>> tb/gamepad_button_autorepeat_tb.sv
// Self-checking testbench for gamepad_button_autorepeat: directed table, then random sample streams.
`timescale 1ns / 1ps
module gamepad_button_autorepeat_tb;
    import gbar_pkg::*;

    localparam int BTN             = BUTTON_COUNT_DEF;
    localparam int LIMIT           = 400000;
    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int N_ROWS          = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [AXIS_W-1:0]    MID_AXIS  = 16'd32768;
    localparam logic [AXIS_W-1:0]    NO_HAT    = 16'hFFFF;
    localparam logic [AXIS_W-1:0]    HAT_SPOTS [5] =
        '{HAT_UP, HAT_RIGHT, HAT_DOWN, HAT_LEFT, NO_HAT};

    typedef struct packed {
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
        logic [AXIS_W-1:0] hat;
        logic [RAW_W-1:0]  raw;
        logic [TIME_W-1:0] now;
    } sample_t;

    typedef struct packed {
        logic [MASK_W-1:0] fire;
        logic [MASK_W-1:0] held;
    } masks_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SMP,
        ROW_CHK
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [AXIS_W-1:0]     x;
        logic [AXIS_W-1:0]     y;
        logic [AXIS_W-1:0]     hat;
        logic [RAW_W-1:0]      raw;
        logic [TIME_W-1:0]     now;
        logic [MASK_W-1:0]     fire;
        logic [MASK_W-1:0]     held;
    } row_t;

    localparam row_t DIR_ROWS [N_ROWS] = '{
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'h0000, 32'd1000, 20'h0, 20'h0},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'hFFFF, 32'd1000,
          20'hFFFF0, 20'hFFFF0},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'hFFFF, 32'd1499,
          20'h00000, 20'hFFFF0},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'hFFFF, 32'd1500,
          20'hFFFF0, 20'hFFFF0},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'hFFFF, 32'd1749,
          20'h00000, 20'hFFFF0},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'hFFFF, 32'd1750,
          20'hFFFF0, 20'hFFFF0},
        '{ROW_CHK, 3'd0, 16'd0, 16'd0, 16'd0, NO_HAT, 16'h0000, 32'd1800, 20'h5, 20'h5},
        '{ROW_CHK, 3'd0, 16'd0, 16'hFFFF, 16'hFFFF, NO_HAT, 16'h0000, 32'd1850, 20'hA, 20'hA},
        '{ROW_SMP, 3'd0, 16'd0, 16'd21844, 16'd43691, NO_HAT, 16'h0000, 32'd1900, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, 16'd43691, 16'd21844, NO_HAT, 16'h0000, 32'd2000, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, 16'd43690, 16'd21845, NO_HAT, 16'h8001, 32'd2100, 20'h0, 20'h0},
        '{ROW_CFG, REG_HAS_HAT, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_CFG, REG_DELAY, 16'hFFFC, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_CFG, REG_SPEED, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_CFG, REG_SPARE, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, HAT_UP, 16'h0000, 32'd3000, 20'h1, 20'h1},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, HAT_RIGHT, 16'h0000, 32'd3010, 20'h8, 20'h8},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, HAT_DOWN, 16'h0000, 32'd3020, 20'h2, 20'h2},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, HAT_LEFT, 16'h0000, 32'd3030, 20'h4, 20'h4},
        '{ROW_CHK, 3'd0, 16'd0, MID_AXIS, MID_AXIS, 16'd27001, 16'h0000, 32'd3040, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'h0001, 32'hFFFF_FF00, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'h0001, 32'h0000_00F9, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'h0001, 32'h0000_0115, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, MID_AXIS, MID_AXIS, NO_HAT, 16'h0001, 32'h0000_0117, 20'h0, 20'h0},
        '{ROW_CFG, REG_X_MIN, 16'd60000, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_CFG, REG_X_MAX, 16'd3000, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, 16'd40999, MID_AXIS, NO_HAT, 16'h0000, 32'h200, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, 16'd41000, MID_AXIS, NO_HAT, 16'h0000, 32'h210, 20'h0, 20'h0},
        '{ROW_CFG, REG_X_MIN, 16'd5000, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_CFG, REG_X_MAX, 16'd5000, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, 16'd5000, MID_AXIS, NO_HAT, 16'h0000, 32'h300, 20'h0, 20'h0},
        '{ROW_SMP, 3'd0, 16'd0, 16'd4999, MID_AXIS, NO_HAT, 16'h0000, 32'h310, 20'h0, 20'h0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sample_valid;
    logic                  sample_stall;
    logic [AXIS_W-1:0]     x_pos;
    logic [AXIS_W-1:0]     y_pos;
    logic [AXIS_W-1:0]     hat_angle;
    logic [RAW_W-1:0]      raw_buttons;
    logic [TIME_W-1:0]     now_ms;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [MASK_W-1:0]     fire_mask;
    logic [MASK_W-1:0]     held_mask;

    logic [AXIS_W-1:0] reg_x_min   = X_MIN_RST;
    logic [AXIS_W-1:0] reg_x_max   = X_MAX_RST;
    logic [AXIS_W-1:0] reg_y_min   = Y_MIN_RST;
    logic [AXIS_W-1:0] reg_y_max   = Y_MAX_RST;
    logic              reg_has_hat = 1'b0;
    logic [1:0]        reg_delay   = DELAY_RST;
    logic [4:0]        reg_speed   = SPEED_RST;

    bit                btn_held [BTN] = '{default: 1'b0};
    logic [TIME_W-1:0] btn_last [BTN];
    bit                btn_rep  [BTN] = '{default: 1'b0};

    masks_t pending_masks [$];
    int     gap_pct     = 0;
    int     stall_left  = 0;
    int     errors      = 0;
    int     n_samples   = 0;
    int     n_checked   = 0;
    int     n_fires     = 0;
    int     n_cfg       = 0;
    int     cycle_count = 0;

    gamepad_button_autorepeat DUT (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic masks_t button_events(input sample_t s);
        int                xmin, xmax, ymin, ymax, dx, dy, xp, yp, span;
        bit                press;
        logic [TIME_W-1:0] elapsed;
        masks_t            m;
        xmin = int'(reg_x_min);
        xmax = int'(reg_x_max);
        ymin = int'(reg_y_min);
        ymax = int'(reg_y_max);
        dx   = xmax - xmin;
        dy   = ymax - ymin;
        xp   = int'(s.x);
        yp   = int'(s.y);
        m    = '0;
        for (int j = 0; j < BTN; j++)
        begin
            case (j)
                0:       press = (yp < ymin + dy / 3) || (reg_has_hat && s.hat == HAT_UP);
                1:       press = (yp > ymax - dy / 3) || (reg_has_hat && s.hat == HAT_DOWN);
                2:       press = (xp < xmin + dx / 3) || (reg_has_hat && s.hat == HAT_LEFT);
                3:       press = (xp > xmax - dx / 3) || (reg_has_hat && s.hat == HAT_RIGHT);
                default: press = (j - DIR_COUNT < RAW_W) && s.raw[j - DIR_COUNT];
            endcase
            if (press)
            begin
                if (btn_held[j])
                begin
                    span    = btn_rep[j] ? 1000 / (reg_speed + 2) : (reg_delay + 1) * 250;
                    elapsed = s.now - btn_last[j];
                    if (elapsed >= span)
                    begin
                        btn_last[j] = s.now;
                        btn_rep[j]  = 1'b1;
                        m.fire[j]   = 1'b1;
                    end
                end
                else
                begin
                    btn_held[j] = 1'b1;
                    btn_last[j] = s.now;
                    btn_rep[j]  = 1'b0;
                    m.fire[j]   = 1'b1;
                end
            end
            else
            begin
                btn_held[j] = 1'b0;
            end
            if (btn_held[j])
                m.held[j] = 1'b1;
        end
        return m;
    endfunction

    // near a threshold, at an extreme, mid-range, or anywhere; mostly hold the last value
    function automatic logic [AXIS_W-1:0] axis_pick(input bit vertical,
                                                   input logic [AXIS_W-1:0] prev);
        int mn, mx, d, lo, hi, v, r;
        mn = vertical ? int'(reg_y_min) : int'(reg_x_min);
        mx = vertical ? int'(reg_y_max) : int'(reg_x_max);
        d  = mx - mn;
        lo = mn + d / 3;
        hi = mx - d / 3;
        r  = $urandom_range(0, 99);
        if (r < 55)
            v = int'(prev);
        else if (r < 66)
            v = lo + int'($urandom_range(0, 4)) - 2;
        else if (r < 77)
            v = hi + int'($urandom_range(0, 4)) - 2;
        else if (r < 84)
            v = $urandom_range(0, 1) ? 65535 : 0;
        else if (r < 90)
            v = (lo + hi) / 2;
        else
            v = $urandom_range(0, 65535);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[AXIS_W-1:0];
    endfunction

    task automatic send_sample(input sample_t s, input bit typed, input masks_t typed_m);
        int     n;
        masks_t m;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            n = $urandom_range(1, 4);
            @(negedge clk);
            sample_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid = 1'b1;
        x_pos        = s.x;
        y_pos        = s.y;
        hat_angle    = s.hat;
        raw_buttons  = s.raw;
        now_ms       = s.now;
        do @(posedge clk); while (sample_stall);
        m = button_events(s);
        pending_masks.push_back(typed ? typed_m : m);
        n_samples++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending_masks.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_X_MIN:   reg_x_min   = data;
            REG_X_MAX:   reg_x_max   = data;
            REG_Y_MIN:   reg_y_min   = data;
            REG_Y_MAX:   reg_y_max   = data;
            REG_HAS_HAT: reg_has_hat = data[0];
            REG_DELAY:   reg_delay   = data[1:0];
            REG_SPEED:   reg_speed   = data[4:0];
            default:     ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall = 1'b1;
        end
        else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            stall_left   = $urandom_range(0, 3);
            result_stall = 1'b1;
        end
        else
        begin
            result_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        masks_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_masks.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: fire %h held %h", $time, fire_mask,
                         held_mask);
            end
            else
            begin
                e = pending_masks.pop_front();
                if (fire_mask !== e.fire)
                begin
                    errors++;
                    $display("%0t fire_mask mismatch: expected %h actual %h", $time, e.fire,
                             fire_mask);
                end
                if (held_mask !== e.held)
                begin
                    errors++;
                    $display("%0t held_mask mismatch: expected %h actual %h", $time, e.held,
                             held_mask);
                end
                n_checked++;
                n_fires += $countones(fire_mask);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
                 pending_masks.size());
        $display("gamepad_button_autorepeat regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        sample_t           s, cur;
        row_t              row;
        masks_t            m;
        int                p, i, r, step;
        logic [15:0]       xa, xb, ya, yb, hh, dl, sp;
        logic [TIME_W-1:0] tick;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_valid = 1'b0;
        x_pos        = MID_AXIS;
        y_pos        = MID_AXIS;
        hat_angle    = NO_HAT;
        raw_buttons  = '0;
        now_ms       = '0;
        cur          = '{MID_AXIS, MID_AXIS, NO_HAT, 16'h0000, 32'd0};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gap_pct = 25;
        for (i = 0; i < N_ROWS; i++)
        begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(row.idx, row.data);
            end
            else
            begin
                s      = '{row.x, row.y, row.hat, row.raw, row.now};
                m.fire = row.fire;
                m.held = row.held;
                send_sample(s, row.kind == ROW_CHK, m);
                cur = s;
            end
        end

        for (p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            gap_pct = (p == 3 || p == N_PHASES - 1) ? 0 : 25;
            case (p)
                0:
                begin
                    xa = 16'h0000; xb = 16'hFFFF; ya = 16'h0000; yb = 16'hFFFF;
                    hh = 16'd1; dl = 16'd0; sp = 16'd31;
                end
                1:
                begin
                    xa = 16'h0000; xb = 16'hFFFF; ya = 16'h0000; yb = 16'hFFFF;
                    hh = 16'd0; dl = 16'd3; sp = 16'd0;
                end
                2:
                begin
                    xa = 16'($urandom_range(32768, 65535)); xb = 16'($urandom_range(0, 32767));
                    ya = 16'($urandom_range(32768, 65535)); yb = 16'($urandom_range(0, 32767));
                    hh = 16'd1; dl = 16'($urandom); sp = 16'($urandom);
                end
                3:
                begin
                    xa = 16'($urandom); xb = xa; ya = 16'($urandom); yb = ya;
                    hh = 16'd0; dl = 16'($urandom); sp = 16'($urandom);
                end
                default:
                begin
                    xa = 16'($urandom); xb = 16'($urandom);
                    ya = 16'($urandom); yb = 16'($urandom);
                    hh = 16'($urandom); dl = 16'($urandom); sp = 16'($urandom);
                end
            endcase
            write_reg(REG_X_MIN, xa);
            write_reg(REG_X_MAX, xb);
            write_reg(REG_Y_MIN, ya);
            write_reg(REG_Y_MAX, yb);
            write_reg(REG_HAS_HAT, hh);
            write_reg(REG_DELAY, dl);
            write_reg(REG_SPEED, sp);
            write_reg(REG_SPARE, 16'($urandom));
            tick = (p % 3 == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;

            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 4 && i == ITEMS_PER_PHASE / 2)
                    wait_idle();
                r = $urandom_range(0, 99);
                if (r < 45)
                    step = $urandom_range(0, 150);
                else if (r < 70)
                    step = ($urandom_range(0, 1) ? (reg_delay + 1) * 250
                                                 : 1000 / (reg_speed + 2))
                           + int'($urandom_range(0, 2)) - 1;
                else if (r < 90)
                    step = $urandom_range(151, 1100);
                else if (r < 95)
                    step = 0;
                else
                    step = $urandom;
                tick = tick + step;

                if ($urandom_range(0, 99) < 8)
                begin
                    s.x   = 16'($urandom);
                    s.y   = 16'($urandom);
                    s.hat = 16'($urandom);
                    s.raw = 16'($urandom);
                    s.now = $urandom;
                end
                else
                begin
                    s.x   = axis_pick(1'b0, cur.x);
                    s.y   = axis_pick(1'b1, cur.y);
                    s.now = tick;
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        s.hat = cur.hat;
                    else if (r < 85)
                        s.hat = HAT_SPOTS[$urandom_range(0, 4)];
                    else if (r < 93)
                        s.hat = HAT_SPOTS[$urandom_range(0, 3)]
                                + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
                    else
                        s.hat = 16'($urandom);
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        s.raw = cur.raw;
                    else if (r < 75)
                        s.raw = cur.raw ^ (16'd1 << $urandom_range(0, RAW_W - 1));
                    else if (r < 85)
                        s.raw = 16'($urandom);
                    else if (r < 90)
                        s.raw = 16'h0000;
                    else if (r < 95)
                        s.raw = 16'hFFFF;
                    else
                        s.raw = cur.raw ^ 16'($urandom & $urandom);
                end
                send_sample(s, 1'b0, '0);
                cur = s;
            end
        end

        wait_idle();
        repeat (BTN + 8) @(posedge clk);
        if (pending_masks.size() != 0)
        begin
            errors += pending_masks.size();
            $display("%0t %0d expected results never arrived", $time, pending_masks.size());
        end
        $display("checked %0d result beats from %0d sample beats across %0d register writes",
                 n_checked, n_samples, n_cfg);
        $display("saw %0d button fire events under random idling and back-pressure", n_fires);
        if (errors == 0)
            $display("gamepad_button_autorepeat regression: pass");
        else
            $display("gamepad_button_autorepeat regression: fail");
        $finish;
    end

endmodule
